/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the block statistics design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define DCB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("block statistics property violated");

// Same-cycle implication, built on the plain form above.
`define DCB_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   `DCB_ASSERT(lbl, clk, rst, (ante) |-> (cons))

`endif

/* rtl/dcb_pkg.sv */
// Shared constants and types of the dual-channel block statistics design.
`default_nettype none

package dcb_pkg;

   // Sample and block size limits.
   localparam int SAMPLE_BITS     = 13;
   localparam int MAX_BLOCK_PAIRS = 4096;
   localparam int MEAN_BITS       = 12;

   // Pair counter holds the limit itself.
   localparam int CNT_BITS = $clog2(MAX_BLOCK_PAIRS + 1);
   // Sum holds MAX_BLOCK_PAIRS full-scale samples plus a sign bit.
   localparam int SUM_BITS = SAMPLE_BITS + CNT_BITS;
   // Positive sums lose the sign bit before division.
   localparam int DIV_BITS = SUM_BITS - 1;
   // Partial remainder of the restoring divider.
   localparam int REM_BITS = CNT_BITS + 1;
   localparam int STEP_BITS = $clog2(DIV_BITS);

   // Depth of the queue between the front and back ends (power of two).
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX_VAL =
      {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN_VAL =
      {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [CNT_BITS-1:0] PAIR_LIMIT = CNT_BITS'(MAX_BLOCK_PAIRS);

   // One closed block, waiting for its means to be computed.
   typedef struct packed {
      logic signed [SUM_BITS-1:0]    sum0;
      logic signed [SUM_BITS-1:0]    sum1;
      logic signed [SAMPLE_BITS-1:0] min0;
      logic signed [SAMPLE_BITS-1:0] max0;
      logic signed [SAMPLE_BITS-1:0] min1;
      logic signed [SAMPLE_BITS-1:0] max1;
      logic [CNT_BITS-1:0]           pairs;
      logic                          overlong;
   } job_type;

   // Write side of the queue.
   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_wr_type;

   // Read side of the queue.
   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_rd_type;

   // One finished result transaction.
   typedef struct packed {
      logic                          overlong;
      logic signed [SAMPLE_BITS-1:0] max1;
      logic signed [SAMPLE_BITS-1:0] min1;
      logic [MEAN_BITS-1:0]          mean1;
      logic signed [SAMPLE_BITS-1:0] max0;
      logic signed [SAMPLE_BITS-1:0] min0;
      logic [MEAN_BITS-1:0]          mean0;
   } result_type;

endpackage

`default_nettype wire

/* rtl/dcb_front.sv */
// Front end: accumulates per-channel sums, minimum and maximum and closes blocks.
`default_nettype none

module dcb_front import dcb_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic signed [SAMPLE_BITS-1:0] sample,
   input  wire logic                          block_end,
   input  wire logic                          q_ready,
   output queue_wr_type                       q_wr
);

   logic signed [SUM_BITS-1:0]    sum0_ff, sum0_in, sum1_ff, sum1_in;
   logic signed [SAMPLE_BITS-1:0] min0_ff, min0_in, max0_ff, max0_in;
   logic signed [SAMPLE_BITS-1:0] min1_ff, min1_in, max1_ff, max1_in;
   logic [CNT_BITS-1:0]           pairs_ff, pairs_in;
   logic                          phase_ff, phase_in;
   logic                          sat_ff, sat_in;

   logic signed [SUM_BITS-1:0]    s_ext;
   logic                          full;
   logic                          accept;
   logic                          close;
   logic signed [SUM_BITS-1:0]    sum1_upd;
   logic signed [SAMPLE_BITS-1:0] min1_upd, max1_upd;
   logic [CNT_BITS-1:0]           pairs_upd;
   logic                          sat_upd;

   // A closing transaction needs a free queue slot, so stall on a full queue.
   assign in_ready = q_ready;
   assign accept   = in_valid && in_ready;
   assign close    = accept && phase_ff && block_end;
   assign full     = pairs_ff >= PAIR_LIMIT;
   assign s_ext    = {{(SUM_BITS-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};

   // Channel 1 statistics including the current sample.
   always_comb begin
      sum1_upd  = full ? sum1_ff : sum1_ff + s_ext;
      pairs_upd = full ? pairs_ff : pairs_ff + CNT_BITS'(1);
      sat_upd   = sat_ff | full;
      min1_upd  = (sample < min1_ff) ? sample : min1_ff;
      max1_upd  = (sample > max1_ff) ? sample : max1_ff;
   end

   // Next state of the accumulators.
   always_comb begin
      sum0_in  = sum0_ff;
      sum1_in  = sum1_ff;
      min0_in  = min0_ff;
      max0_in  = max0_ff;
      min1_in  = min1_ff;
      max1_in  = max1_ff;
      pairs_in = pairs_ff;
      phase_in = phase_ff;
      sat_in   = sat_ff;
      if (accept) begin
         if (!phase_ff) begin
            sum0_in  = full ? sum0_ff : sum0_ff + s_ext;
            sat_in   = sat_ff | full;
            min0_in  = (sample < min0_ff) ? sample : min0_ff;
            max0_in  = (sample > max0_ff) ? sample : max0_ff;
            phase_in = 1'b1;
         end else if (block_end) begin
            // Block closes: everything returns to its starting values.
            sum0_in  = '0;
            sum1_in  = '0;
            min0_in  = SAMPLE_MAX_VAL;
            max0_in  = SAMPLE_MIN_VAL;
            min1_in  = SAMPLE_MAX_VAL;
            max1_in  = SAMPLE_MIN_VAL;
            pairs_in = '0;
            sat_in   = 1'b0;
            phase_in = 1'b0;
         end else begin
            sum1_in  = sum1_upd;
            pairs_in = pairs_upd;
            sat_in   = sat_upd;
            min1_in  = min1_upd;
            max1_in  = max1_upd;
            phase_in = 1'b0;
         end
      end
   end

   // Hand the closed block to the queue.
   always_comb begin
      q_wr.valid        = close;
      q_wr.job.sum0     = sum0_ff;
      q_wr.job.sum1     = sum1_upd;
      q_wr.job.min0     = min0_ff;
      q_wr.job.max0     = max0_ff;
      q_wr.job.min1     = min1_upd;
      q_wr.job.max1     = max1_upd;
      q_wr.job.pairs    = pairs_upd;
      q_wr.job.overlong = sat_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum0_ff  <= '0;
         sum1_ff  <= '0;
         min0_ff  <= SAMPLE_MAX_VAL;
         max0_ff  <= SAMPLE_MIN_VAL;
         min1_ff  <= SAMPLE_MAX_VAL;
         max1_ff  <= SAMPLE_MIN_VAL;
         pairs_ff <= '0;
         phase_ff <= 1'b0;
         sat_ff   <= 1'b0;
      end else begin
         sum0_ff  <= sum0_in;
         sum1_ff  <= sum1_in;
         min0_ff  <= min0_in;
         max0_ff  <= max0_in;
         min1_ff  <= min1_in;
         max1_ff  <= max1_in;
         pairs_ff <= pairs_in;
         phase_ff <= phase_in;
         sat_ff   <= sat_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/dcb_queue.sv */
// Short queue of closed blocks between the front end and the divider.
`default_nettype none

module dcb_queue import dcb_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire queue_wr_type wr,
   output logic              wr_ready,
   output queue_rd_type      rd,
   input  wire logic         rd_pop
);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;
   logic                   push, pop;

   assign wr_ready = count_ff != (QPTR_BITS+1)'(QUEUE_DEPTH);
   assign rd.valid = count_ff != '0;
   assign rd.job   = entry_ff[rd_ptr_ff];
   assign push     = wr.valid && wr_ready;
   assign pop      = rd_pop && rd.valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_BITS+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr.job;
      end
   end

endmodule

`default_nettype wire

/* rtl/dcb_back.sv */
// Back end: divides both channel sums by the pair count and holds the result.
`default_nettype none

module dcb_back import dcb_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire queue_rd_type q_rd,
   output logic              q_pop,
   output logic              out_valid,
   input  wire logic         out_ready,
   output result_type        out_result
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   job_type              job_ff;
   logic [DIV_BITS-1:0]  dvd_ff [2];
   logic [DIV_BITS-1:0]  dvd_in [2];
   logic [REM_BITS-1:0]  rem_ff [2];
   logic [REM_BITS-1:0]  rem_in [2];
   logic                 out_valid_ff, out_valid_in;
   result_type           result_ff;

   logic                 load, take, last_step;
   logic [REM_BITS-1:0]  trial [2];
   logic [REM_BITS-1:0]  divisor;
   logic                 ge [2];
   logic signed [SUM_BITS-1:0] lane_sum [2];
   logic [MEAN_BITS-1:0] mean [2];

   assign load      = (state_ff == ST_IDLE) && q_rd.valid;
   assign q_pop     = load;
   assign take      = (state_ff == ST_DONE) && (!out_valid_ff || out_ready);
   assign last_step = step_ff == STEP_BITS'(DIV_BITS - 1);
   assign divisor   = {1'b0, job_ff.pairs};
   assign lane_sum[0] = q_rd.job.sum0;
   assign lane_sum[1] = q_rd.job.sum1;

   // Restoring division, one quotient bit per cycle in each lane.
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         trial[l]  = {rem_ff[l][REM_BITS-2:0], dvd_ff[l][DIV_BITS-1]};
         ge[l]     = trial[l] >= divisor;
         dvd_in[l] = dvd_ff[l];
         rem_in[l] = rem_ff[l];
         if (load) begin
            // Zero and negative sums give a zero mean.
            dvd_in[l] = (!lane_sum[l][SUM_BITS-1] && lane_sum[l] != '0) ?
                        lane_sum[l][DIV_BITS-1:0] : '0;
            rem_in[l] = '0;
         end else if (state_ff == ST_DIV) begin
            dvd_in[l] = {dvd_ff[l][DIV_BITS-2:0], ge[l]};
            rem_in[l] = ge[l] ? trial[l] - divisor : trial[l];
         end
         // Quotient clamped to the mean field.
         mean[l] = (|dvd_ff[l][DIV_BITS-1:MEAN_BITS]) ? '1 : dvd_ff[l][MEAN_BITS-1:0];
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (load) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            step_in = step_ff + STEP_BITS'(1);
            if (last_step) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: a waiting result does not block the next division.
   assign out_valid_in = take ? 1'b1 : (out_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      if (load) begin
         job_ff <= q_rd.job;
      end
      if (take) begin
         result_ff.mean0    <= mean[0];
         result_ff.min0     <= job_ff.min0;
         result_ff.max0     <= job_ff.max0;
         result_ff.mean1    <= mean[1];
         result_ff.min1     <= job_ff.min1;
         result_ff.max1     <= job_ff.max1;
         result_ff.overlong <= job_ff.overlong;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

endmodule

`default_nettype wire

/* rtl/dual_channel_block_min_max_mean.sv */
// Top level of the dual-channel block statistics design: minimum, maximum and mean.
//
// Channels 0 and 1 alternate, one sample per clock while req_tready is high.
// Per channel the block keeps a sum, a minimum and a maximum; a sample with
// tlast set on channel 1 closes the block (tlast on channel 0 is ignored).
// A closed block enters a two-entry queue and a restoring divider computes
// both means in parallel, one quotient bit per cycle, one block at a time,
// into the output register. Input is accepted every cycle as long as the
// queue has room, so only very short blocks arriving back to back, or a
// stalled result channel, hold the input off. Blocks longer than 4096 pairs
// stop summing after 4096 pairs and are flagged on rsp_tuser.
`default_nettype none
`include "assert_macros.svh"

module dual_channel_block_min_max_mean import dcb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [12:0] sample, [15:13] zero
   input  wire logic [15:0] req_tdata,
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [11:0] mean_ch0, [24:12] min_ch0, [37:25] max_ch0, [49:38] mean_ch1,
   // [62:50] min_ch1, [75:63] max_ch1, [79:76] zero
   output logic [79:0]      rsp_tdata,
   // [0] overlong
   output logic             rsp_tuser
);

   queue_wr_type q_wr;
   queue_rd_type q_rd;
   logic         q_ready;
   logic         q_pop;
   result_type   result;

   dcb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .sample    (req_tdata[SAMPLE_BITS-1:0]),
      .block_end (req_tlast),
      .q_ready   (q_ready),
      .q_wr      (q_wr)
   );

   dcb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr       (q_wr),
      .wr_ready (q_ready),
      .rd       (q_rd),
      .rd_pop   (q_pop)
   );

   dcb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_rd       (q_rd),
      .q_pop      (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   // Result transaction packing.
   assign rsp_tdata = {4'b0, result.max1, result.min1, result.mean1,
                       result.max0, result.min0, result.mean0};
   assign rsp_tuser = result.overlong;

   // A closed block is never dropped at the queue.
   `DCB_ASSERT_IMPL(a_push_has_room, clock, reset, q_wr.valid, q_ready)
   // Every block holds at least one sample per channel, so min never exceeds max.
   `DCB_ASSERT_IMPL(a_order_ch0, clock, reset, rsp_tvalid, result.min0 <= result.max0)
   `DCB_ASSERT_IMPL(a_order_ch1, clock, reset, rsp_tvalid, result.min1 <= result.max1)

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the dual-channel block minimum, maximum and mean statistics unit.
module testbench;
   import dcb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MEAN_LIMIT = (1 << MEAN_BITS) - 1;
   localparam int LONG_HOLD  = 300;
   localparam int RANDOM_ITEMS = 1350;

   // Value ranges used to shape the samples of one channel over a block.
   typedef enum int unsigned {
      SPREAD_FULL,
      SPREAD_POSITIVE,
      SPREAD_NEGATIVE,
      SPREAD_EXTREME
   } spread_type;

   // Statistics reported for one closed block.
   typedef struct {
      logic [MEAN_BITS-1:0]          mean0;
      logic signed [SAMPLE_BITS-1:0] min0;
      logic signed [SAMPLE_BITS-1:0] max0;
      logic [MEAN_BITS-1:0]          mean1;
      logic signed [SAMPLE_BITS-1:0] min1;
      logic signed [SAMPLE_BITS-1:0] max1;
      logic                          overlong;
   } block_stats_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        rsp_tuser;

   // Running statistics of the block currently being received.
   longint                        sum_ch0;
   longint                        sum_ch1;
   logic signed [SAMPLE_BITS-1:0] low_ch0;
   logic signed [SAMPLE_BITS-1:0] high_ch0;
   logic signed [SAMPLE_BITS-1:0] low_ch1;
   logic signed [SAMPLE_BITS-1:0] high_ch1;
   int unsigned                   pairs_seen;
   bit                            awaiting_ch1;
   bit                            capped;

   block_stats_type pending_stats[$];
   int              error_count = 0;

   // Idle control shared between the stimulus and the result sink.
   bit sender_steady = 1'b0;
   bit sink_steady   = 1'b0;
   bit hold_request  = 1'b0;

   dual_channel_block_min_max_mean uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // Return the statistics of the next block to their starting values.
   function automatic void clear_block();
      sum_ch0      = 0;
      sum_ch1      = 0;
      low_ch0      = SAMPLE_MAX_VAL;
      high_ch0     = SAMPLE_MIN_VAL;
      low_ch1      = SAMPLE_MAX_VAL;
      high_ch1     = SAMPLE_MIN_VAL;
      pairs_seen   = 0;
      awaiting_ch1 = 1'b0;
      capped       = 1'b0;
   endfunction

   // Truncated mean with negative results clamped to zero and large ones to full scale.
   function automatic logic [MEAN_BITS-1:0] block_mean(input longint total,
                                                       input int unsigned count);
      longint quotient;
      if (count == 0 || total <= 0)
         return '0;
      quotient = total / longint'(count);
      if (quotient > MEAN_LIMIT)
         quotient = MEAN_LIMIT;
      return quotient[MEAN_BITS-1:0];
   endfunction

   // Fold one accepted sample into the running statistics; a closing sample queues a result.
   function automatic void absorb_sample(input logic signed [SAMPLE_BITS-1:0] value,
                                         input logic mark);
      bit              full;
      block_stats_type stats;
      full = (pairs_seen >= MAX_BLOCK_PAIRS);
      if (!awaiting_ch1) begin
         if (full)
            capped = 1'b1;
         else
            sum_ch0 += value;
         if (value < low_ch0)
            low_ch0 = value;
         if (value > high_ch0)
            high_ch0 = value;
         awaiting_ch1 = 1'b1;
         return;
      end
      if (full) begin
         capped = 1'b1;
      end else begin
         sum_ch1 += value;
         pairs_seen++;
      end
      if (value < low_ch1)
         low_ch1 = value;
      if (value > high_ch1)
         high_ch1 = value;
      awaiting_ch1 = 1'b0;
      if (!mark)
         return;
      stats.mean0    = block_mean(sum_ch0, pairs_seen);
      stats.min0     = low_ch0;
      stats.max0     = high_ch0;
      stats.mean1    = block_mean(sum_ch1, pairs_seen);
      stats.min1     = low_ch1;
      stats.max1     = high_ch1;
      stats.overlong = capped;
      pending_stats.push_back(stats);
      clear_block();
   endfunction

   function automatic void compare_field(input string label, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         error_count++;
      end
   endfunction

   // Compare one result transaction with the oldest outstanding block.
   function automatic void check_result(input logic [79:0] data, input logic flag);
      block_stats_type want;
      if (pending_stats.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual data %h overlong %b",
                  $time, data, flag);
         error_count++;
         return;
      end
      want = pending_stats.pop_front();
      compare_field("mean_ch0", want.mean0, data[11:0]);
      compare_field("min_ch0", want.min0, $signed(data[24:12]));
      compare_field("max_ch0", want.max0, $signed(data[37:25]));
      compare_field("mean_ch1", want.mean1, data[49:38]);
      compare_field("min_ch1", want.min1, $signed(data[62:50]));
      compare_field("max_ch1", want.max1, $signed(data[75:63]));
      compare_field("overlong", want.overlong, flag);
   endfunction

   // Offer one sample after a random gap, or none if sender_steady, and wait until it is accepted.
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic mark);
      int unsigned gap;
      gap = sender_steady ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, value};
      req_tlast  <= mark;
      do @(posedge clock); while (!req_tready);
      absorb_sample(value, mark);
   endtask

   task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] first,
                            input logic first_mark,
                            input logic signed [SAMPLE_BITS-1:0] second,
                            input logic closes);
      send_sample(first, first_mark);
      send_sample(second, closes);
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] draw_value(input spread_type spread);
      case (spread)
         SPREAD_POSITIVE: return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX_VAL));
         SPREAD_NEGATIVE: return SAMPLE_BITS'(SAMPLE_MIN_VAL +
                                              $urandom_range(0, SAMPLE_MAX_VAL));
         SPREAD_EXTREME:  return $urandom_range(0, 1) ? SAMPLE_MAX_VAL : SAMPLE_MIN_VAL;
         default:         return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // Full-scale samples, clamping of negative means, truncation and ignored channel 0 marks.
   task automatic test_extreme_values();
      send_pair(SAMPLE_MAX_VAL, 1'b0, SAMPLE_MAX_VAL, 1'b1);
      send_pair(SAMPLE_MIN_VAL, 1'b0, SAMPLE_MIN_VAL, 1'b1);
      send_pair(SAMPLE_MIN_VAL, 1'b1, SAMPLE_MAX_VAL, 1'b0);
      send_pair(SAMPLE_MAX_VAL, 1'b1, SAMPLE_MIN_VAL, 1'b1);
      send_pair(13'sd1, 1'b0, -13'sd1, 1'b0);
      send_pair(13'sd1, 1'b1, 13'sd0, 1'b0);
      send_pair(13'sd2, 1'b0, 13'sd4, 1'b1);
      send_pair(-13'sd5, 1'b0, -13'sd3, 1'b0);
      send_pair(13'sd1, 1'b1, -13'sd3, 1'b1);
   endtask

   // A block of exactly the pair limit, then one that runs past it.
   task automatic test_block_length_limit();
      logic signed [SAMPLE_BITS-1:0] first;
      logic signed [SAMPLE_BITS-1:0] second;
      sender_steady = 1'b1;
      sink_steady   = 1'b1;
      for (int unsigned p = 0; p < MAX_BLOCK_PAIRS; p++)
         send_pair(SAMPLE_MAX_VAL, 1'b0, draw_value(SPREAD_POSITIVE), p == MAX_BLOCK_PAIRS - 1);
      // Past the limit only the extremes arrive, so they must show up in min and max alone.
      for (int unsigned p = 0; p < MAX_BLOCK_PAIRS + 4; p++) begin
         if (p < MAX_BLOCK_PAIRS) begin
            first  = SAMPLE_BITS'($urandom_range(0, 2000) - 1000);
            second = SAMPLE_BITS'($urandom_range(0, 2000) - 1000);
         end else begin
            first  = p[0] ? SAMPLE_MAX_VAL : SAMPLE_MIN_VAL;
            second = p[0] ? SAMPLE_MIN_VAL : SAMPLE_MAX_VAL;
         end
         send_pair(first, 1'b0, second, p == MAX_BLOCK_PAIRS + 3);
      end
      sender_steady = 1'b0;
      sink_steady   = 1'b0;
   endtask

   // Short blocks keep coming while the result side is held off, so the input backs up.
   task automatic test_output_stall();
      sender_steady = 1'b1;
      hold_request  = 1'b1;
      for (int unsigned b = 0; b < 16; b++)
         send_pair(draw_value(SPREAD_FULL), 1'b0, draw_value(SPREAD_FULL), 1'b1);
      sender_steady = 1'b0;
   endtask

   task automatic test_random_blocks();
      int unsigned items;
      int unsigned pairs;
      spread_type  spread0;
      spread_type  spread1;
      items = 0;
      while (items < RANDOM_ITEMS) begin
         pairs   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
         spread0 = spread_type'($urandom_range(0, 3));
         spread1 = spread_type'($urandom_range(0, 3));
         sender_steady = ($urandom_range(0, 3) == 0);
         sink_steady   = ($urandom_range(0, 3) == 0);
         for (int unsigned p = 0; p < pairs; p++)
            send_pair(draw_value(spread0), $urandom_range(0, 3) == 0,
                      draw_value(spread1), p == pairs - 1);
         items += 2 * pairs;
      end
   endtask

   // Result sink: random stalls, one long hold-off on request, and a check of each transaction.
   initial begin : result_sink
      int unsigned pause;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            pause = LONG_HOLD;
         end else begin
            pause = sink_steady ? 0 : $urandom_range(0, 19);
         end
         if (pause != 0) begin
            rsp_tready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         check_result(rsp_tdata, rsp_tuser);
      end
   end

   // Main sequence: reset, the tests in turn, then drain and report.
   initial begin
      clear_block();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_extreme_values();
      test_block_length_limit();
      test_output_stall();
      test_random_blocks();
      req_tvalid <= 1'b0;
      while (pending_stats.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog for a stuck handshake.
   initial begin
      #1_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
